>>> sv/lhq_pkg.sv
// Shared types, constants and helper functions for the log2 histogram quantile block.
// No dependencies.
package lhq_pkg;

    localparam int DEF_NUM_BUCKETS     = 64;
    localparam int DEF_COUNT_WIDTH     = 32;
    localparam int DEF_QUANT_FRAC_BITS = 20;

    localparam int SAMPLE_WIDTH = 64;
    localparam int MID_WIDTH    = 64;
    localparam int IDX_WIDTH    = 6;
    localparam int TOTAL_WIDTH  = 32;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [MID_WIDTH-1:0] MID_NOT_FOUND = {1'b1, {(MID_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic found;
    } t_walk_ctl;

    // bucket 0 -> 1, bucket i -> 3 * 2^(i-1)
    function automatic logic [MID_WIDTH-1:0] bucket_midpoint(input logic [IDX_WIDTH-1:0] idx);
        logic [MID_WIDTH-1:0] mid;
        if (idx == '0) begin
            mid = MID_WIDTH'(1);
        end else begin
            mid = MID_WIDTH'(3) << (idx - IDX_WIDTH'(1));
        end
        return mid;
    endfunction

endpackage

>>> sv/lhq_cell.sv
// One histogram bucket: saturating counter plus one stage of the cumulative-sum walk.
// Depends on lhq_pkg.
module lhq_cell #(
    parameter int CW  = lhq_pkg::DEF_COUNT_WIDTH,
    parameter int BW  = 6,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_add,
    input  logic [BW-1:0]        i_add_idx,
    input  logic                 i_clear,
    input  logic [CW-1:0]        i_target,
    input  lhq_pkg::t_walk_ctl   i_ctl,
    input  logic [CW+BW-1:0]     i_cum,
    input  logic [BW-1:0]        i_idx,
    output lhq_pkg::t_walk_ctl   o_ctl,
    output logic [CW+BW-1:0]     o_cum,
    output logic [BW-1:0]        o_idx
);

    localparam logic [BW-1:0] MY_IDX = BW'(IDX);

    logic [CW-1:0]       r_count, n_count;
    lhq_pkg::t_walk_ctl  r_ctl, n_ctl;
    logic [CW+BW-1:0]    r_cum, n_cum;
    logic [BW-1:0]       r_idx, n_idx;
    logic                reached;

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_add && (i_add_idx == MY_IDX) && (r_count != '1)) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_cum   = i_cum + (CW+BW)'(r_count);
        reached = (n_cum >= (CW+BW)'(i_target));
        n_ctl   = i_ctl;
        n_idx   = i_idx;
        if (i_ctl.valid && !i_ctl.found && reached) begin
            n_ctl.found = 1'b1;
            n_idx       = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ctl   <= '0;
        end else begin
            r_count <= n_count;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum <= n_cum;
        r_idx <= n_idx;
    end

    assign o_ctl = r_ctl;
    assign o_cum = r_cum;
    assign o_idx = r_idx;

endmodule

>>> sv/log2_histogram_quantile_top.sv
// Top level of the log2 latency histogram with quantile query.
// Depends on lhq_pkg and lhq_cell.
//
// Usage: drive i_operation, i_sample_value and i_quantile_fraction with start.
// A transaction is taken at a rising edge where start is high and busy is low.
//   add   : one transaction per cycle, takes effect on the accept edge, no result.
//   clear : zeroes all buckets and the total, no result.
//   query : busy from the accept edge until the result is registered;
//           o_result_valid pulses for one cycle with the result. The query
//           steps through the target multiply (S_MUL), the ceiling round
//           (S_TGT) and the launch (S_LAUNCH), then the cumulative sum passes
//           one bucket cell per cycle, and the result is registered.
//   code 3: ignored.
// Results carry midpoint, bucket index, total, empty and not-found flags.
// The receiver cannot stall; o_result_valid is high for exactly one cycle.
// Reset (i_rst_n low, synchronous) zeroes all bucket counters and the total
// at once and returns the controller to idle; no clearing pass is needed.
module log2_histogram_quantile_top #(
    parameter int NUM_BUCKETS     = lhq_pkg::DEF_NUM_BUCKETS,
    parameter int COUNT_WIDTH     = lhq_pkg::DEF_COUNT_WIDTH,
    parameter int QUANT_FRAC_BITS = lhq_pkg::DEF_QUANT_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic [lhq_pkg::SAMPLE_WIDTH-1:0]  i_sample_value,
    input  logic [QUANT_FRAC_BITS:0]          i_quantile_fraction,
    output logic                              o_result_valid,
    output logic [lhq_pkg::MID_WIDTH-1:0]     o_midpoint_ns,
    output logic [lhq_pkg::IDX_WIDTH-1:0]     o_hit_bucket,
    output logic [lhq_pkg::TOTAL_WIDTH-1:0]   o_total_count,
    output logic                              o_histogram_empty,
    output logic                              o_target_not_found
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int CW = COUNT_WIDTH;
    localparam int QW = QUANT_FRAC_BITS + 1;
    localparam int PW = QW + CW;
    localparam logic [QW-1:0] Q_ONE    = {1'b1, {QUANT_FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] CEIL_ADD = PW'({QUANT_FRAC_BITS{1'b1}});
    localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BUCKETS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TGT,
        S_LAUNCH,
        S_WALK
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_total;
    logic [QW-1:0]   r_q;
    logic [PW-1:0]   r_prod;
    logic [CW-1:0]   r_target;

    logic            accept;
    logic            do_add;
    logic            do_clear;
    logic [BW-1:0]   add_idx;
    logic [lhq_pkg::IDX_WIDTH-1:0] log2_idx;
    logic [PW-1:0]   prod_round;
    logic [63:0]     total_ext;

    lhq_pkg::t_walk_ctl w_ctl [0:NUM_BUCKETS];
    logic [CW+BW-1:0]   w_cum [0:NUM_BUCKETS];
    logic [BW-1:0]      w_idx [0:NUM_BUCKETS];

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign do_add   = accept && (i_operation == lhq_pkg::OP_ADD);
    assign do_clear = accept && (i_operation == lhq_pkg::OP_CLEAR);

    always_comb begin
        log2_idx = '0;
        for (int b = 0; b < lhq_pkg::SAMPLE_WIDTH; b++) begin
            if (i_sample_value[b]) begin
                log2_idx = lhq_pkg::IDX_WIDTH'(b);
            end
        end
        if ({1'b0, log2_idx} >= 7'(NUM_BUCKETS)) begin
            add_idx = LAST_IDX;
        end else begin
            add_idx = log2_idx[BW-1:0];
        end
    end

    assign prod_round = r_prod + CEIL_ADD;

    assign w_ctl[0] = '{valid: (r_state == S_LAUNCH), found: 1'b0};
    assign w_cum[0] = '0;
    assign w_idx[0] = '0;

    for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
        lhq_cell #(
            .CW  (CW),
            .BW  (BW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_add     (do_add),
            .i_add_idx (add_idx),
            .i_clear   (do_clear),
            .i_target  (r_target),
            .i_ctl     (w_ctl[g]),
            .i_cum     (w_cum[g]),
            .i_idx     (w_idx[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_cum     (w_cum[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

    assign total_ext = 64'(r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_total        <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (do_clear) begin
                r_total <= '0;
            end else if (do_add && (r_total != '1)) begin
                r_total <= r_total + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_operation == lhq_pkg::OP_QUERY)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:    r_state <= S_TGT;
                S_TGT:    r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_WALK;
                S_WALK: begin
                    if (w_ctl[NUM_BUCKETS].valid) begin
                        r_state        <= S_IDLE;
                        o_result_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= (i_quantile_fraction > Q_ONE) ? Q_ONE : i_quantile_fraction;
        end
        r_prod   <= PW'(r_q) * PW'(r_total);
        r_target <= prod_round[QUANT_FRAC_BITS +: CW];
        if (r_state == S_WALK) begin
            o_total_count <= total_ext[lhq_pkg::TOTAL_WIDTH-1:0];
            if (r_total == '0) begin
                o_midpoint_ns      <= '0;
                o_hit_bucket       <= '0;
                o_histogram_empty  <= 1'b1;
                o_target_not_found <= 1'b0;
            end else if (!w_ctl[NUM_BUCKETS].found) begin
                o_midpoint_ns      <= lhq_pkg::MID_NOT_FOUND;
                o_hit_bucket       <= '0;
                o_histogram_empty  <= 1'b0;
                o_target_not_found <= 1'b1;
            end else begin
                o_midpoint_ns      <= lhq_pkg::bucket_midpoint(
                                          lhq_pkg::IDX_WIDTH'(w_idx[NUM_BUCKETS]));
                o_hit_bucket       <= lhq_pkg::IDX_WIDTH'(w_idx[NUM_BUCKETS]);
                o_histogram_empty  <= 1'b0;
                o_target_not_found <= 1'b0;
            end
        end
    end

    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_WALK))
        else $error("result without a walk");

    a_no_walk_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ctl[NUM_BUCKETS].valid)
        else $error("walk token at chain end while idle");

    a_empty_excludes_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_histogram_empty) |-> !o_target_not_found)
        else $error("empty and not-found both set");

    a_found_mid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_histogram_empty && !o_target_not_found)
            |-> (o_midpoint_ns != '0))
        else $error("found bucket with zero midpoint");

endmodule
